// File: hdl/h264sc_pkg.sv
// Shared constants and types for the H.264 Annex B start-code NAL extractor.
// Depends on nothing; imported by the top-level module, the checker and the testbench.
`default_nettype none

package h264sc_pkg;

  // Field widths fixed by the result format.
  localparam int BYTE_W  = 8;
  localparam int MAXP_W  = 21;
  localparam int TRUNC_W = 24;

  // Default width of the per-unit byte counter.
  localparam int COUNT_WIDTH_DEF = 24;

  // Byte that completes a start code after two or more zero bytes.
  localparam logic [BYTE_W-1:0] START_BYTE = 8'h01;

  // Reset value of the payload limit register.
  localparam logic [MAXP_W-1:0] MAXP_RESET = 21'd65536;

  // Saturation value of the truncated count.
  localparam logic [TRUNC_W-1:0] TRUNC_MAX = 24'hFF_FFFF;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Work decoded from one input byte, carried out one step per cycle unless the output stalls:
  // an optional summary of the old unit, payload attempts, a closing summary.
  typedef struct packed {
    logic              pre_sum;   // summary of the unit that a start code closes
    logic              clr;       // a new unit begins: count starts from zero
    logic [2:0]        npay;      // payload attempts still to make
    logic [BYTE_W-1:0] obyte;     // final payload byte (zero for held zeros)
    logic              post_sum;  // summary at end of buffer
  } op_t;

endpackage

`default_nettype wire

// File: hdl/h264_start_code_nal_extractor.sv
// Top level of the H.264 Annex B start-code NAL extractor.
// Depends on h264sc_pkg for widths, constants and the step record type.
`default_nettype none

// One byte of the stream is taken per request on the input channel. Bytes
// before the first start code are dropped; after a start code the NAL payload
// comes out one byte per result, followed by a summary result with the
// emitted and truncated byte counts when the next start code or the end of the
// buffer closes the unit. Each input byte is decoded as it is accepted into a
// short list of steps, and one step is carried out per clock unless the output
// stalls, so the block sustains one byte per clock on ordinary payload. A byte
// that releases held zero bytes or ends a buffer causes up to five results and
// then occupies the step sequencer with one step per result (suppressed payload
// bytes also take a step each), which holds off the next input request until
// its last step is carried out. A registered output stage lets a new byte be
// accepted while a result waits to be taken. The user must write max_payload_bytes
// through cfg_write/cfg_data only while idle; the block does not enforce this.
module h264_start_code_nal_extractor
  import h264sc_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // Configuration
  input  wire logic               cfg_write,
  input  wire logic [MAXP_W-1:0]  cfg_data,
  // Input channel
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic [BYTE_W-1:0]  data_byte,
  input  wire logic               end_of_buffer,
  // Output channel
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic               kind,
  output      logic [BYTE_W-1:0]  payload_byte,
  output      logic [MAXP_W-1:0]  emitted_count,
  output      logic [TRUNC_W-1:0] truncated_count,
  output      logic               last
);

  localparam int CMP_W = (COUNT_WIDTH > MAXP_W) ? COUNT_WIDTH : MAXP_W;
  localparam int TR_W  = (CMP_W > TRUNC_W) ? CMP_W : TRUNC_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // Registers
  logic [MAXP_W-1:0]      max_payload_bytes;
  logic [1:0]             held_count;
  logic                   inside_unit;
  logic [COUNT_WIDTH-1:0] unit_byte_count;
  logic                   op_valid;
  op_t                    op;

  // Decode of the incoming byte
  logic       in_accept;
  logic       is_zero;
  logic       is_start;
  logic [1:0] held_after;
  logic       inside_after;
  logic [2:0] npay_byte;
  logic [1:0] held_next;
  logic       inside_next;
  op_t        op_next;

  // Step execution
  logic                   step_pre;
  logic                   step_pay;
  logic                   step_post;
  logic                   step_last;
  logic                   step_fire;
  logic                   step_emit;
  logic                   out_free;
  logic [COUNT_WIDTH-1:0] eff;
  logic [COUNT_WIDTH-1:0] eff_inc;
  logic [CMP_W-1:0]       eff_ext;
  logic [CMP_W-1:0]       inc_ext;
  logic [CMP_W-1:0]       max_ext;
  logic                   pay_ok;
  logic                   next_ok;
  logic [MAXP_W-1:0]      sum_em;
  logic [CMP_W-1:0]       tr_full;
  logic [TR_W-1:0]        tr_wide;
  logic [TRUNC_W-1:0]     sum_tr;
  logic [COUNT_WIDTH-1:0] count_next;
  logic                   res_kind;
  logic [BYTE_W-1:0]      res_byte;
  logic                   res_last;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_bytes <= MAXP_RESET;
    end else if (cfg_write) begin
      max_payload_bytes <= cfg_data;
    end
  end

  // Decode one byte against the held zeros. The window only ever holds zero
  // bytes, so a count of held bytes is all the state it needs.
  always_comb begin
    is_zero  = (data_byte == '0);
    is_start = (data_byte == START_BYTE) && (held_count >= 2'd2);

    if (is_start) begin
      held_after = 2'd0;
    end else if (is_zero) begin
      held_after = (held_count == 2'd3) ? 2'd3 : held_count + 2'd1;
    end else begin
      held_after = 2'd0;
    end
    inside_after = inside_unit | is_start;

    // Payload attempts caused by the byte itself.
    if (is_start || !inside_unit) begin
      npay_byte = 3'd0;
    end else if (is_zero) begin
      npay_byte = (held_count == 2'd3) ? 3'd1 : 3'd0;
    end else begin
      npay_byte = {1'b0, held_count} + 3'd1;
    end

    op_next.pre_sum = is_start && inside_unit;
    op_next.clr     = is_start;
    op_next.obyte   = (!is_start && !is_zero && inside_unit) ? data_byte : '0;
    if (end_of_buffer && inside_after) begin
      op_next.npay     = npay_byte + {1'b0, held_after};
      op_next.post_sum = 1'b1;
    end else begin
      op_next.npay     = npay_byte;
      op_next.post_sum = 1'b0;
    end

    held_next   = end_of_buffer ? 2'd0 : held_after;
    inside_next = end_of_buffer ? 1'b0 : inside_after;
  end

  // Current step of the sequencer and the result it makes.
  always_comb begin
    step_pre  = op.pre_sum;
    step_pay  = !op.pre_sum && (op.npay != 3'd0);
    step_post = !op.pre_sum && (op.npay == 3'd0) && op.post_sum;

    if (step_pre) begin
      step_last = !op.post_sum && (op.npay == 3'd0);
    end else if (step_pay) begin
      step_last = (op.npay == 3'd1) && !op.post_sum;
    end else begin
      step_last = 1'b1;
    end

    // The summary of the closing unit still sees its own count.
    eff     = (op.clr && !op.pre_sum) ? '0 : unit_byte_count;
    eff_inc = (eff == COUNT_MAX) ? eff : eff + COUNT_WIDTH'(1);
    eff_ext = CMP_W'(eff);
    inc_ext = CMP_W'(eff_inc);
    max_ext = CMP_W'(max_payload_bytes);
    pay_ok  = (eff_ext < max_ext);
    next_ok = (inc_ext < max_ext);

    // Summary counts: emitted is min(count, limit); the rest is truncated.
    sum_em  = pay_ok ? eff_ext[MAXP_W-1:0] : max_payload_bytes;
    tr_full = eff_ext - CMP_W'(sum_em);
    tr_wide = TR_W'(tr_full);
    sum_tr  = (tr_wide > TR_W'(TRUNC_MAX)) ? TRUNC_MAX : tr_wide[TRUNC_W-1:0];

    step_emit = op_valid && (step_pre || step_post || (step_pay && pay_ok));
    out_free  = !out_valid || !out_stall;
    step_fire = op_valid && (!step_emit || out_free);

    if (step_pre) begin
      count_next = '0;
    end else if (step_pay) begin
      count_next = eff_inc;
    end else begin
      count_next = eff;
    end

    res_kind = step_pay ? KIND_PAYLOAD : KIND_SUMMARY;
    res_byte = (step_pay && (op.npay == 3'd1)) ? op.obyte : '0;
    // A payload is the final result once no later payload can pass the limit.
    res_last = step_last || (step_pay && !op.post_sum && !next_ok);

    in_stall  = op_valid && !(step_fire && step_last);
    in_accept = in_valid && !in_stall;
  end

  // Window and unit state, updated as each request is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count  <= 2'd0;
      inside_unit <= 1'b0;
    end else if (in_accept) begin
      held_count  <= held_next;
      inside_unit <= inside_next;
    end
  end

  // Step sequencer and the running byte count of the unit.
  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid        <= 1'b0;
      unit_byte_count <= '0;
    end else begin
      if (step_fire) begin
        unit_byte_count <= count_next;
      end
      if (in_accept) begin
        op_valid <= 1'b1;
      end else if (step_fire && step_last) begin
        op_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op <= op_next;
    end else if (step_fire) begin
      op.clr <= 1'b0;
      if (step_pre) begin
        op.pre_sum <= 1'b0;
      end else if (step_pay) begin
        op.npay <= op.npay - 3'd1;
      end else begin
        op.post_sum <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step_fire && step_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && step_fire && step_emit) begin
      kind            <= res_kind;
      payload_byte    <= res_byte;
      emitted_count   <= step_pay ? '0 : sum_em;
      truncated_count <= step_pay ? '0 : sum_tr;
      last            <= res_last;
    end
  end

endmodule

`default_nettype wire

// File: tb/h264sc_checker.sv
// Checker for the H.264 Annex B start-code NAL extractor: watches both channels and
// the limit register, predicts every result and compares it field by field.
// Depends on h264sc_pkg for widths, the start byte and the result kinds.
`default_nettype none

module h264sc_checker
  import h264sc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [MAXP_W-1:0]  cfg_data,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [BYTE_W-1:0]  data_byte,
  input  wire logic               end_of_buffer,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic               kind,
  input  wire logic [BYTE_W-1:0]  payload_byte,
  input  wire logic [MAXP_W-1:0]  emitted_count,
  input  wire logic [TRUNC_W-1:0] truncated_count,
  input  wire logic               last,
  output int                      mismatches,
  output int                      pending
);

  localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;
  localparam logic [23:0]       COUNT_SAT = 24'hFF_FFFF;

  typedef struct packed {
    logic               kind;
    logic [BYTE_W-1:0]  pbyte;
    logic [MAXP_W-1:0]  emitted;
    logic [TRUNC_W-1:0] truncated;
    logic               last;
  } nal_result_t;

  nal_result_t        unit_results_q[$];  // results still owed by the block
  nal_result_t        byte_results_q[$];  // results of the request being predicted
  logic [MAXP_W-1:0]  payload_limit;
  logic [23:0]        zero_window;        // held bytes, newest in the low byte
  int                 zeros_held;
  bit                 in_unit;
  logic [23:0]        unit_bytes;
  int                 fail_total;

  // A payload byte goes out only while the unit is under its limit.
  task automatic emit_payload(input logic [BYTE_W-1:0] b);
    nal_result_t r;
    r = '0;
    r.kind = KIND_PAYLOAD;
    r.pbyte = b;
    if (unit_bytes < 24'(payload_limit)) byte_results_q.push_back(r);
    if (unit_bytes != COUNT_SAT) unit_bytes++;
  endtask

  // The truncated count cannot exceed its field here, as the unit count is 24 bits.
  task automatic emit_summary();
    nal_result_t r;
    logic [23:0] sent;
    sent = (unit_bytes < 24'(payload_limit)) ? unit_bytes : 24'(payload_limit);
    r = '0;
    r.kind = KIND_SUMMARY;
    r.emitted = sent[MAXP_W-1:0];
    r.truncated = unit_bytes - sent;
    byte_results_q.push_back(r);
  endtask

  // Held zeros turn out to be payload: release them oldest first.
  task automatic release_zeros();
    for (int i = zeros_held - 1; i >= 0; i--) emit_payload(zero_window[8*i +: 8]);
    zeros_held = 0;
    zero_window = '0;
  endtask

  task automatic predict_byte(input logic [BYTE_W-1:0] b, input logic eob);
    bit start_code;
    int idx;
    start_code = (b == START_BYTE) && (zeros_held >= 2) && (zero_window[15:0] == 16'h0);
    byte_results_q.delete();
    if (start_code) begin
      // A start code closes any open unit and opens an empty one.
      if (in_unit) emit_summary();
      in_unit = 1'b1;
      unit_bytes = '0;
      zeros_held = 0;
      zero_window = '0;
    end else if (b == ZERO_BYTE) begin
      // A fourth zero pushes the oldest one out as payload.
      if (zeros_held >= 3) begin
        if (in_unit) emit_payload(zero_window[23:16]);
        zeros_held = 3;
      end else begin
        zeros_held++;
      end
      zero_window = {zero_window[15:0], b};
    end else begin
      if (in_unit) begin
        release_zeros();
        emit_payload(b);
      end
      zeros_held = 0;
      zero_window = '0;
    end
    // End of buffer flushes and closes the unit, then searching starts again.
    if (eob) begin
      if (in_unit) begin
        release_zeros();
        emit_summary();
      end
      in_unit = 1'b0;
      unit_bytes = '0;
      zeros_held = 0;
      zero_window = '0;
    end
    if (byte_results_q.size() > 0) begin
      idx = byte_results_q.size() - 1;
      byte_results_q[idx].last = 1'b1;
    end
    foreach (byte_results_q[i]) unit_results_q.push_back(byte_results_q[i]);
  endtask

  task automatic note_failure(input string msg);
    if (fail_total < 10) $display("mismatch: %s", msg);
    fail_total++;
  endtask

  // Requests are predicted before results are checked at the same edge.
  always @(posedge clk) begin
    nal_result_t want;
    if (rst) begin
      unit_results_q.delete();
      payload_limit = MAXP_RESET;
      zero_window = '0;
      zeros_held = 0;
      in_unit = 1'b0;
      unit_bytes = '0;
      fail_total = 0;
    end else begin
      if (cfg_write) payload_limit = cfg_data;
      if (in_valid && !in_stall) predict_byte(data_byte, end_of_buffer);
      if (out_valid && !out_stall) begin
        if (unit_results_q.size() == 0) begin
          note_failure($sformatf("unexpected result kind=%0b byte=%02h em=%0d tr=%0d last=%0b",
                                 kind, payload_byte, emitted_count, truncated_count, last));
        end else begin
          want = unit_results_q.pop_front();
          if (kind !== want.kind || payload_byte !== want.pbyte ||
              emitted_count !== want.emitted || truncated_count !== want.truncated ||
              last !== want.last) begin
            note_failure($sformatf(
              "expected kind=%0b byte=%02h em=%0d tr=%0d last=%0b, got %0b %02h %0d %0d %0b",
              want.kind, want.pbyte, want.emitted, want.truncated, want.last,
              kind, payload_byte, emitted_count, truncated_count, last));
          end
        end
      end
    end
    mismatches <= fail_total;
    pending <= unit_results_q.size();
  end

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Testbench top for the H.264 Annex B start-code NAL extractor: clock, reset,
// byte stream stimulus, random output stalls and the verdict.
// Depends on h264sc_pkg, the extractor RTL and h264sc_checker.
`default_nettype none

module tb_top;
  import h264sc_pkg::*;

  localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_PERCENT  = 29;

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [MAXP_W-1:0]  cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [BYTE_W-1:0]  data_byte = '0;
  logic               end_of_buffer = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               kind;
  logic [BYTE_W-1:0]  payload_byte;
  logic [MAXP_W-1:0]  emitted_count;
  logic [TRUNC_W-1:0] truncated_count;
  logic               last;

  int fail_count;
  int pending_results;
  int cycle_count = 0;
  int bytes_sent = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_go = 1'b0;

  h264_start_code_nal_extractor dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .end_of_buffer(end_of_buffer),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .payload_byte(payload_byte), .emitted_count(emitted_count),
    .truncated_count(truncated_count), .last(last)
  );

  h264sc_checker scoreboard (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .end_of_buffer(end_of_buffer),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .payload_byte(payload_byte), .emitted_count(emitted_count),
    .truncated_count(truncated_count), .last(last),
    .mismatches(fail_count), .pending(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit: a hang or a lost result ends here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off when asked for.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= rx_idle_on && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // One request: random gaps first, then hold the byte until it is taken.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eob);
    while (tx_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    end_of_buffer <= eob;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Stop offering and wait until every owed result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  // Suppressed payload bytes may keep the block busy after the last result.
  task automatic write_limit(input logic [MAXP_W-1:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Payload bytes lean towards zeros and start bytes to provoke near-misses.
  function automatic logic [BYTE_W-1:0] pick_payload();
    int r;
    r = $urandom_range(99);
    if (r < 30) return ZERO_BYTE;
    if (r < 40) return START_BYTE;
    if (r < 45) return 8'hFF;
    return 8'($urandom);
  endfunction

  // A well-formed unit: 3- or 4-byte start code, then a random payload.
  task automatic send_unit();
    int len;
    logic eob_at_end;
    len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
    eob_at_end = ($urandom_range(99) < 30);
    if ($urandom_range(1) == 1) send_byte(ZERO_BYTE, 1'b0);
    send_byte(ZERO_BYTE, 1'b0);
    send_byte(ZERO_BYTE, 1'b0);
    send_byte(START_BYTE, eob_at_end && len == 0);
    for (int i = 0; i < len; i++) send_byte(pick_payload(), eob_at_end && i == len - 1);
  endtask

  // Mostly units, some raw noise; the stream closes with an end of buffer.
  task automatic send_stream(input int count);
    int goal;
    int n;
    goal = bytes_sent + count;
    while (bytes_sent < goal) begin
      if ($urandom_range(99) < 15) begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(8'($urandom), $urandom_range(9) == 0);
      end else begin
        send_unit();
      end
    end
    send_byte(pick_payload(), 1'b1);
  endtask

  // Stimulus: directed cases, then random streams under several limits.
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Junk before the first start code, then a 3-byte start code.
    send_byte(8'h7F, 1'b0);
    send_byte(ZERO_BYTE, 1'b0); send_byte(ZERO_BYTE, 1'b0); send_byte(START_BYTE, 1'b0);
    // Payload extremes; a start byte after a single zero is plain payload.
    send_byte(8'hFF, 1'b0); send_byte(START_BYTE, 1'b0);
    send_byte(ZERO_BYTE, 1'b0); send_byte(START_BYTE, 1'b0);
    // Four zeros push one out, then a 4-byte start code closes the unit.
    repeat (4) send_byte(ZERO_BYTE, 1'b0);
    send_byte(START_BYTE, 1'b0);
    // Held zeros flushed by an end of buffer.
    send_byte(8'h80, 1'b0); send_byte(ZERO_BYTE, 1'b0); send_byte(ZERO_BYTE, 1'b1);
    // Start code as the last byte of a buffer: an empty unit.
    send_byte(ZERO_BYTE, 1'b0); send_byte(ZERO_BYTE, 1'b0); send_byte(START_BYTE, 1'b1);
    // End of buffer while searching gives nothing.
    send_byte(ZERO_BYTE, 1'b1);
    // Three held zeros and a final byte: the most results from one request.
    repeat (3) send_byte(ZERO_BYTE, 1'b0);
    send_byte(START_BYTE, 1'b0);
    repeat (3) send_byte(ZERO_BYTE, 1'b0);
    send_byte(8'h42, 1'b1);

    write_limit('0);
    send_stream(20);
    write_limit(21'd1);
    send_stream(15);

    // A long stretch without idling on either side.
    write_limit(21'd3);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_stream(30);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;

    // Receiver holds off while the sender keeps going, so the block backs up.
    write_limit(21'd1048576);
    hold_go = 1'b1;
    send_stream(25);

    // Limit at the top of its range; the sender pauses mid-stream until all is out.
    write_limit(21'h1F_FFFF);
    send_stream(10);
    drain();
    send_stream(10);

    write_limit(MAXP_W'($urandom_range(2, 16)));
    send_stream(20);
    write_limit(MAXP_W'($urandom_range(0, 1048576)));
    send_stream(20);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
